### sv/two_wire_humidity_sensor_master_core_macros.svh
// assertion macros for the two-wire humidity sensor master checker
// each macro expects clk and arst_n to be visible where it is used
`ifndef TWO_WIRE_HUMIDITY_SENSOR_MASTER_CORE_MACROS_SVH
`define TWO_WIRE_HUMIDITY_SENSOR_MASTER_CORE_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TWHSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked at every rising clock edge outside reset
`define TWHSM_ASSERT_IMPL(label, ante, cons, msg) \
	`TWHSM_ASSERT(label, (ante) |-> (cons), msg)

`endif

### sv/twhsm_pkg.sv
// shared types and constants of the two-wire humidity sensor master
// used by the core and by its port checker, no dependencies
package twhsm_pkg;

	localparam int unsigned RESET_TOGGLES = 18;
	localparam logic [2:0]  ERR_MAX       = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_TEMP_CMD   = 2'd0;
	localparam logic [1:0] REG_HUMI_CMD   = 2'd1;
	localparam logic [1:0] REG_SETTLE     = 2'd2;
	localparam logic [1:0] REG_TIMEOUT    = 2'd3;

	// configuration reset values
	localparam logic [7:0]  TEMP_CMD_RST  = 8'h03;
	localparam logic [7:0]  HUMI_CMD_RST  = 8'h05;
	localparam logic [7:0]  SETTLE_RST    = 8'd10;
	localparam logic [15:0] TIMEOUT_RST   = 16'hFFFF;

	// one result item, first member at the top bits
	typedef struct packed {
		logic [2:0]  error_count;
		logic [15:0] humidity_raw;
		logic [15:0] temperature_raw;
		logic        done_res;
		logic        busy_res;
		logic        sda_oe;
		logic        sda_out;
		logic        scl;
	} result_t;

endpackage

### sv/two_wire_humidity_sensor_master_core.sv
// two-wire humidity sensor master core: bus state machine advanced once per tick item
// depends on twhsm_pkg
//
// usage:
//   s_* channel carries one bus timing tick per item (start request, sampled data line),
//   normally fed from an external prescaler. each accepted item advances the bus
//   sequencer by one step and gives exactly one result item on the m_* channel with
//   the clock level, data drive and enable, busy, done, both readings and the error
//   count. a start while idle runs a temperature and then a humidity measurement.
//   throughput: one item per cycle while s_tready is high; the sequencer step is a
//   single combinational pass between the state registers and the result register.
//   stall: a result register plus one skid entry; with m_tready low the core takes
//   one more item, then drops s_tready until the result register drains.
//   reset: sequencer idle, lines released, readings and errors zero, configuration
//   registers back to their defaults (commands 3 and 5, settle 10, timeout 65535).
//   configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
//   only while idle, the core itself does not enforce this.
module two_wire_humidity_sensor_master_core
	import twhsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] start_req, [1] sda_in, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // scl, sda_out, sda_oe, busy_res, done_res,
	                               // temperature_raw[15:0], humidity_raw[15:0],
	                               // error_count[2:0]
);

	typedef enum logic [4:0] {
		P_IDLE, P_CRESET, P_TS0, P_TS1, P_TS2, P_TS3, P_TS4, P_TS5, P_TS6,
		P_WB_SET, P_WB_HIGH, P_WA_REL, P_WA_HIGH, P_WA_LOW, P_SETTLE, P_POLL,
		P_RB_HIGH, P_RB_LOW, P_RK_SET, P_RK_HIGH, P_RK_LOW
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  bit_pos;
		logic [15:0] tick;
		logic [7:0]  shift;
		logic        meas_humi;
		logic        low_byte;
		logic [15:0] temp_val;
		logic [15:0] humi_val;
		logic [2:0]  errors;
		logic        clk_lvl;
		logic        data_lvl;
		logic        data_en;
	} st_t;

	logic [7:0]  temp_cmd_q, humi_cmd_q, settle_q;
	logic [15:0] timeout_q;
	st_t         st_q;
	st_t         nxt;
	logic        done_c;
	result_t     res_c;
	result_t     out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        accept, start, sda;
	logic [15:0] limit;

	assign start    = s_tdata[0];
	assign sda      = s_tdata[1];
	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign limit    = (timeout_q != 16'd0) ? timeout_q : 16'd1;

	always_comb begin
		nxt    = st_q;
		done_c = 1'b0;
		case (st_q.phase)
			P_IDLE: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001;
				if (start) begin
					nxt.errors    = 3'd0;
					nxt.meas_humi = 1'b0;
					nxt.low_byte  = 1'b0;
					nxt.tick      = 16'd0;
					nxt.phase     = P_CRESET;
				end
			end
			P_CRESET: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = {!st_q.clk_lvl, 2'b01};
				nxt.tick = st_q.tick + 16'd1;
				if (nxt.tick >= 16'(RESET_TOGGLES)) begin
					nxt.tick  = 16'd0;
					nxt.phase = P_TS0;
				end
			end
			// transmission start: data falls while clock high, clock pulses low, data rises while clock high
			P_TS0: begin {nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001; nxt.phase = P_TS1; end
			P_TS1: begin {nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b101; nxt.phase = P_TS2; end
			P_TS2: begin {nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b110; nxt.phase = P_TS3; end
			P_TS3: begin {nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b010; nxt.phase = P_TS4; end
			P_TS4: begin {nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b110; nxt.phase = P_TS5; end
			P_TS5: begin {nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b101; nxt.phase = P_TS6; end
			P_TS6: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001;
				nxt.shift   = st_q.meas_humi ? humi_cmd_q : temp_cmd_q;
				nxt.bit_pos = 4'd0;
				nxt.phase   = P_WB_SET;
			end
			P_WB_SET: begin
				// msb first
				{nxt.clk_lvl, nxt.data_en} = 2'b01;
				nxt.data_lvl = st_q.shift[~st_q.bit_pos[2:0]];
				nxt.phase    = P_WB_HIGH;
			end
			P_WB_HIGH: begin
				nxt.clk_lvl = 1'b1;
				nxt.bit_pos = st_q.bit_pos + 4'd1;
				nxt.phase   = (nxt.bit_pos >= 4'd8) ? P_WA_REL : P_WB_SET;
			end
			P_WA_REL: begin {nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001; nxt.phase = P_WA_HIGH; end
			P_WA_HIGH: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b101;
				if (sda && st_q.errors < ERR_MAX) nxt.errors = st_q.errors + 3'd1;
				nxt.phase = P_WA_LOW;
			end
			P_WA_LOW: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001;
				nxt.tick  = 16'd0;
				nxt.phase = (settle_q == 8'd0) ? P_POLL : P_SETTLE;
			end
			P_SETTLE: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001;
				nxt.tick = st_q.tick + 16'd1;
				if (nxt.tick >= {8'd0, settle_q}) begin
					nxt.tick  = 16'd0;
					nxt.phase = P_POLL;
				end
			end
			P_POLL: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001;
				nxt.tick = st_q.tick + 16'd1;
				if (!sda || nxt.tick >= limit) begin
					// timeout counts as an error, the read goes ahead anyway
					if (sda && st_q.errors < ERR_MAX) nxt.errors = st_q.errors + 3'd1;
					nxt.tick     = 16'd0;
					nxt.low_byte = 1'b0;
					nxt.bit_pos  = 4'd0;
					nxt.shift    = 8'd0;
					nxt.phase    = P_RB_HIGH;
				end
			end
			P_RB_HIGH: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b101;
				nxt.shift = {st_q.shift[6:0], sda};
				nxt.phase = P_RB_LOW;
			end
			P_RB_LOW: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001;
				nxt.bit_pos = st_q.bit_pos + 4'd1;
				nxt.phase   = (nxt.bit_pos >= 4'd8) ? P_RK_SET : P_RB_HIGH;
			end
			P_RK_SET: begin
				if (st_q.meas_humi) begin
					if (st_q.low_byte) nxt.humi_val[7:0]  = st_q.shift;
					else               nxt.humi_val[15:8] = st_q.shift;
				end else begin
					if (st_q.low_byte) nxt.temp_val[7:0]  = st_q.shift;
					else               nxt.temp_val[15:8] = st_q.shift;
				end
				// acknowledge the msb, leave the lsb unacknowledged
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = {2'b01, st_q.low_byte};
				nxt.phase = P_RK_HIGH;
			end
			P_RK_HIGH: begin nxt.clk_lvl = 1'b1; nxt.phase = P_RK_LOW; end
			P_RK_LOW: begin
				nxt.clk_lvl = 1'b0;
				if (!st_q.low_byte) begin
					nxt.low_byte = 1'b1;
					nxt.bit_pos  = 4'd0;
					nxt.shift    = 8'd0;
					nxt.phase    = P_RB_HIGH;
				end else begin
					nxt.low_byte = 1'b0;
					if (!st_q.meas_humi) begin
						nxt.meas_humi = 1'b1;
						nxt.tick      = 16'd0;
						nxt.phase     = P_CRESET;
					end else begin
						nxt.meas_humi = 1'b0;
						nxt.phase     = P_IDLE;
						done_c        = 1'b1;
					end
				end
			end
			default: begin
				{nxt.clk_lvl, nxt.data_en, nxt.data_lvl} = 3'b001;
				nxt.phase = P_IDLE;
			end
		endcase
	end

	always_comb begin
		res_c.scl             = nxt.clk_lvl;
		res_c.sda_out         = nxt.data_en ? nxt.data_lvl : 1'b1;
		res_c.sda_oe          = nxt.data_en;
		res_c.busy_res        = (nxt.phase != P_IDLE);
		res_c.done_res        = done_c;
		res_c.temperature_raw = nxt.temp_val;
		res_c.humidity_raw    = nxt.humi_val;
		res_c.error_count     = nxt.errors;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cmd_q <= TEMP_CMD_RST;
			humi_cmd_q <= HUMI_CMD_RST;
			settle_q   <= SETTLE_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_CMD: temp_cmd_q <= cfg_data[7:0];
				REG_HUMI_CMD: humi_cmd_q <= cfg_data[7:0];
				REG_SETTLE:   settle_q   <= cfg_data[7:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: P_IDLE, bit_pos: 4'd0, tick: 16'd0, shift: 8'd0,
				meas_humi: 1'b0, low_byte: 1'b0, temp_val: 16'd0, humi_val: 16'd0,
				errors: 3'd0, clk_lvl: 1'b0, data_lvl: 1'b1, data_en: 1'b0};
		end else if (accept) begin
			st_q <= nxt;
		end
	end

	// result register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (accept)  out_q <= res_c;
		end else if (accept) begin
			skid_q <= res_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### sv/twhsm_checker.sv
// port checker for the two-wire humidity sensor master core, bound to the core module
// depends on twhsm_pkg and two_wire_humidity_sensor_master_core_macros.svh
`include "two_wire_humidity_sensor_master_core_macros.svh"

module twhsm_checker
	import twhsm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	result_t res;

	assign res = m_tdata;

	// stalled result holds
	`TWHSM_ASSERT_IMPL(a_stall_hold, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)), "result changed while stalled")

	// the done tick leaves the sequencer idle
	`TWHSM_ASSERT_IMPL(a_done_idle, m_tvalid && res.done_res, !res.busy_res, "done shown while busy")

	// error count saturates at four
	`TWHSM_ASSERT_IMPL(a_err_sat, m_tvalid, !(res.error_count[2] && (res.error_count[1] || res.error_count[0])), "error count above four")

	// released data line reads high
	`TWHSM_ASSERT_IMPL(a_release_high, m_tvalid && !res.sda_oe, res.sda_out, "released data line not high")

endmodule

bind two_wire_humidity_sensor_master_core twhsm_checker u_twhsm_checker (.*);
